### rtl/mbrs_pkg.sv
`timescale 1ns / 1ps
package mbrs_pkg;
  localparam int REG_COUNT_DEF = 8;
  localparam int RX_DEPTH_DEF = 32;
  localparam int READ_LIMIT = 8;
  localparam logic [7:0] FN_READ = 8'h03;
  localparam logic [7:0] FN_WRITE1 = 8'h06;
  localparam logic [7:0] FN_WRITEN = 8'h10;
  localparam logic [7:0] ADDR_DEF = 8'h02;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [0:0] REG_DEVADDR = 1'b0;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage

### rtl/modbus_rtu_register_slave_core.sv
`timescale 1ns / 1ps
// Modbus RTU slave serving holding registers (functions 3, 6 and 16).
// in_*: received request bytes, in_tdata = rx_byte, in_tlast = frame end
// from an external silence timer. Each byte is folded into the CRC and, while
// the store has room, stored as it is accepted; in_tready drops while a frame
// is judged, while its registers are written and while its reply goes out.
// out_*: reply bytes in wire order, out_tdata = tx_byte, out_tlast on the
// final CRC byte. Body bytes (from the captured header, the computed byte count
// or the register file, a registered read) pass S_TX_RD then S_TX; CRC bytes
// go out from S_TX directly. Judging reads the header in S_H0 to S_H6 and
// checks it in S_CHK; a frame with no reply then returns to S_RX. Writes pass
// S_WR0 and S_WR1; for function 16, S_WR1 takes each high byte, then writes.
// A stalled out_tready holds the reply byte and the sequencer.
// cfg_*: APB port; register 0 at address 0 is device_address (reset 2).
// Reset clears counters and presets CRC; register contents read back as 1..N
// until written. Malformed, foreign or broadcast frames are dropped silently.
module modbus_rtu_register_slave_core #(
  parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF,
  parameter int RX_DEPTH  = mbrs_pkg::RX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW = $clog2(RX_DEPTH);
  localparam int CW = $clog2(RX_DEPTH + 1);
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  typedef enum logic [3:0] {
    S_RX, S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_CHK,
    S_WR0, S_WR1, S_TX_RD, S_TX
  } state_t;

  state_t       state_r;
  logic [7:0]   dev_addr_r;
  logic [CW-1:0] cnt_r;
  logic         ovf_r;
  logic [15:0]  crc_r;
  logic [7:0]   hdr_r [6];
  logic [4:0]   idx_r;    // reply byte / write index
  logic [4:0]   len_r;    // reply body length
  logic [15:0]  tcrc_r;
  logic [7:0]   wr_hi_r;
  logic         wr_go_r;
  logic         fn3_r;
  logic [7:0]   obyte_r;
  logic         olast_r;
  logic         ovalid_r;

  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;
  logic [RW-1:0] rf_raddr, rf_waddr;
  logic [15:0]   rf_rdata, rf_wdata;
  logic          rf_we;
  logic          acc;

  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_RX);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == mbrs_pkg::REG_DEVADDR) ? {24'd0, dev_addr_r} : 32'd0;
  assign out_tvalid = ovalid_r;
  assign out_tdata = obyte_r;
  assign out_tlast = olast_r;

  mbrs_rx_store #(.RX_DEPTH(RX_DEPTH)) u_store (
    .clk(clk), .we(acc && (cnt_r < CW'(RX_DEPTH))), .waddr(cnt_r[AW-1:0]),
    .wdata(in_tdata), .raddr(st_raddr), .rdata(st_rdata)
  );

  mbrs_reg_file #(.REG_COUNT(REG_COUNT)) u_regs (
    .clk(clk), .rst_n(rst_n), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  logic [16:0] start_w, qty_w, end_w;
  logic [4:0]  tidx;     // index into reply data for fn3
  logic [5:0]  rd_pos;   // store position for fn16 write data
  assign start_w = {1'b0, hdr_r[2], hdr_r[3]};
  assign qty_w   = {1'b0, hdr_r[4], hdr_r[5]};
  assign end_w   = start_w + qty_w;
  assign tidx    = idx_r - 5'd3;
  assign rd_pos  = 6'd7 + {idx_r, 1'b0};

  // store read address
  always_comb begin
    st_raddr = '0;
    unique case (state_r)
      S_H0: st_raddr = AW'(0);
      S_H1: st_raddr = AW'(1);
      S_H2: st_raddr = AW'(2);
      S_H3: st_raddr = AW'(3);
      S_H4: st_raddr = AW'(4);
      S_H5: st_raddr = AW'(5);
      S_H6: st_raddr = AW'(6);
      S_WR0: st_raddr = AW'(rd_pos);
      S_WR1: st_raddr = AW'(rd_pos + 6'd1);
      default: st_raddr = '0;
    endcase
  end

  assign rf_raddr = RW'(start_w[15:0] + 16'(tidx[4:1]));
  assign rf_waddr = RW'(start_w[15:0] + 16'(idx_r));
  assign rf_wdata = (fn3_r) ? 16'd0 :
                    ((hdr_r[1] == mbrs_pkg::FN_WRITE1) ? {hdr_r[4], hdr_r[5]}
                                                       : {wr_hi_r, st_rdata});
  assign rf_we = ((state_r == S_WR1) && (hdr_r[1] == mbrs_pkg::FN_WRITE1)) || wr_go_r;

  // byte 6 arrives on the store read port in S_CHK
  logic ok;
  logic [4:0] nlen;
  always_comb begin
    ok = !ovf_r && (cnt_r >= CW'(8)) && (crc_r == 16'd0) && (hdr_r[0] != 8'd0)
         && (hdr_r[0] == dev_addr_r);
    nlen = 5'd6;
    if (hdr_r[1] == mbrs_pkg::FN_READ) begin
      ok = ok && (cnt_r == CW'(8)) && (qty_w >= 17'd1) && (qty_w <= 17'(mbrs_pkg::READ_LIMIT))
           && (end_w <= 17'(REG_COUNT));
      nlen = 5'(3 + 2 * qty_w[3:0]);
    end else if (hdr_r[1] == mbrs_pkg::FN_WRITE1) begin
      ok = ok && (cnt_r == CW'(8)) && (start_w < 17'(REG_COUNT));
    end else if (hdr_r[1] == mbrs_pkg::FN_WRITEN) begin
      ok = ok && (qty_w >= 17'd1) && (end_w <= 17'(REG_COUNT))
           && ({9'd0, st_rdata} == {qty_w[15:0], 1'b0})
           && ({{(17-CW){1'b0}}, cnt_r} == 17'd9 + {qty_w[15:0], 1'b0});
    end else begin
      ok = 1'b0;
    end
  end

  logic [7:0] body_byte;
  always_comb begin
    if (idx_r < 5'd6 && !(fn3_r && idx_r >= 5'd2)) begin
      body_byte = hdr_r[3'(idx_r)];
    end else if (idx_r == 5'd2) begin
      body_byte = 8'({qty_w[3:0], 1'b0});
    end else begin
      body_byte = tidx[0] ? rf_rdata[7:0] : rf_rdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RX;
      dev_addr_r <= mbrs_pkg::ADDR_DEF;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      crc_r      <= mbrs_pkg::CRC_INIT;
      ovalid_r   <= 1'b0;
      wr_go_r    <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == mbrs_pkg::REG_DEVADDR) begin
        dev_addr_r <= cfg_pwdata[7:0];
      end
      if (ovalid_r && out_tready && state_r != S_TX) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_RX: if (acc) begin
          if (cnt_r < CW'(RX_DEPTH)) cnt_r <= cnt_r + CW'(1);
          else ovf_r <= 1'b1;
          crc_r <= mbrs_pkg::crc_byte(crc_r, in_tdata);
          if (in_tlast) state_r <= S_H0;
        end
        S_H0: state_r <= S_H1;
        S_H1: begin hdr_r[0] <= st_rdata; state_r <= S_H2; end
        S_H2: begin hdr_r[1] <= st_rdata; state_r <= S_H3; end
        S_H3: begin hdr_r[2] <= st_rdata; state_r <= S_H4; end
        S_H4: begin hdr_r[3] <= st_rdata; state_r <= S_H5; end
        S_H5: begin hdr_r[4] <= st_rdata; state_r <= S_H6; end
        S_H6: begin hdr_r[5] <= st_rdata; state_r <= S_CHK; end
        S_CHK: begin
          fn3_r  <= (hdr_r[1] == mbrs_pkg::FN_READ);
          len_r  <= nlen;
          idx_r  <= '0;
          tcrc_r <= mbrs_pkg::CRC_INIT;
          cnt_r  <= '0;
          ovf_r  <= 1'b0;
          crc_r  <= mbrs_pkg::CRC_INIT;
          if (!ok) state_r <= S_RX;
          else if (hdr_r[1] == mbrs_pkg::FN_READ) state_r <= S_TX_RD;
          else state_r <= S_WR0;
        end
        S_WR0: state_r <= S_WR1;
        S_WR1: begin
          if (hdr_r[1] == mbrs_pkg::FN_WRITE1) begin
            idx_r <= '0;
            state_r <= S_TX_RD;
          end else if (!wr_go_r) begin
            wr_hi_r <= st_rdata;
            wr_go_r <= 1'b1;
          end else begin
            wr_go_r <= 1'b0;
            if (17'(idx_r) + 17'd1 >= qty_w) begin
              idx_r <= '0;
              state_r <= S_TX_RD;
            end else begin
              idx_r <= idx_r + 5'd1;
              state_r <= S_WR0;
            end
          end
        end
        S_TX_RD: state_r <= S_TX;
        S_TX: if (!ovalid_r || out_tready) begin
          ovalid_r <= 1'b1;
          if (idx_r < len_r) begin
            obyte_r <= body_byte;
            olast_r <= 1'b0;
            tcrc_r  <= mbrs_pkg::crc_byte(tcrc_r, body_byte);
            idx_r   <= idx_r + 5'd1;
            state_r <= S_TX_RD;
          end else if (idx_r == len_r) begin
            obyte_r <= tcrc_r[7:0];
            olast_r <= 1'b0;
            idx_r   <= idx_r + 5'd1;
          end else begin
            obyte_r <= tcrc_r[15:8];
            olast_r <= 1'b1;
            state_r <= S_RX;
          end
        end
        default: state_r <= S_RX;
      endcase
    end
  end
endmodule

### rtl/mbrs_rx_store.sv
`timescale 1ns / 1ps
module mbrs_rx_store #(
  parameter int RX_DEPTH = mbrs_pkg::RX_DEPTH_DEF,
  localparam int AW = $clog2(RX_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [RX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/mbrs_reg_file.sv
`timescale 1ns / 1ps
module mbrs_reg_file #(
  parameter int REG_COUNT = mbrs_pkg::REG_COUNT_DEF,
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [RW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [RW-1:0] raddr,
  output logic [15:0]   rdata
);
  logic [15:0]        mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic                 rvalid_r;
  logic [RW-1:0]        raddr_r;
  logic [15:0]          mem_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q    <= mem[raddr];
    rvalid_r <= valid_r[raddr];
    raddr_r  <= raddr;
  end

  assign rdata = rvalid_r ? mem_q : (16'(raddr_r) + 16'd1);
endmodule

### tb/modbus_rtu_register_slave_core_test.sv
`timescale 1ns / 1ps
module modbus_rtu_register_slave_core_test;
  localparam int NREG = mbrs_pkg::REG_COUNT_DEF;
  localparam int DEPTH = mbrs_pkg::RX_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_FRAME = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  modbus_rtu_register_slave_core dut (.*);

  logic [7:0]  m_store [DEPTH];
  int          m_count;
  logic        m_ovf;
  logic [15:0] m_regs [NREG];
  logic [15:0] m_crc;
  logic [7:0]  m_addr;

  reply_byte_t reply_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          replies_seen = 0;
  int          frames_sent;
  int          out_wait;
  int          out_draw;

  logic [7:0]  fbuf [MAX_FRAME];
  int          flen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic push_reply(input logic [7:0] body[], input int len);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int k = 0; k < len; k++) begin
      c = crc_step(c, body[k]);
      reply_q.push_back('{body[k], 1'b0});
    end
    reply_q.push_back('{c[7:0], 1'b0});
    reply_q.push_back('{c[15:8], 1'b1});
  endtask

  task automatic judge_request();
    logic [7:0]  body[];
    logic [31:0] start, qty;
    logic [7:0]  fn;
    if (m_ovf || m_count < 4 || m_crc != 16'h0000) return;
    if (m_store[0] == 8'h00 || m_store[0] != m_addr) return;
    fn = m_store[1];
    if (m_count < 8) return;
    start = {m_store[2], m_store[3]};
    qty = {m_store[4], m_store[5]};
    if (fn == mbrs_pkg::FN_READ) begin
      if (m_count != 8 || qty < 1 || qty > mbrs_pkg::READ_LIMIT || start + qty > NREG) return;
      body = new[3 + 2 * qty];
      body[0] = m_addr;
      body[1] = mbrs_pkg::FN_READ;
      body[2] = 8'(qty * 2);
      for (int k = 0; k < qty; k++) begin
        body[3 + 2 * k] = m_regs[start + k][15:8];
        body[4 + 2 * k] = m_regs[start + k][7:0];
      end
      push_reply(body, 3 + 2 * qty);
    end else if (fn == mbrs_pkg::FN_WRITE1) begin
      if (m_count != 8 || start >= NREG) return;
      m_regs[start] = qty[15:0];
      body = new[6];
      for (int k = 0; k < 6; k++) body[k] = m_store[k];
      push_reply(body, 6);
    end else if (fn == mbrs_pkg::FN_WRITEN) begin
      if (qty < 1 || start + qty > NREG) return;
      if (m_store[6] != qty * 2 || m_count != 9 + qty * 2) return;
      for (int k = 0; k < qty; k++) m_regs[start + k] = {m_store[7 + 2 * k], m_store[8 + 2 * k]};
      body = new[6];
      for (int k = 0; k < 6; k++) body[k] = m_store[k];
      push_reply(body, 6);
    end
  endtask

  task automatic model_byte(input logic [7:0] b, input logic fend);
    if (m_count < DEPTH) begin
      m_store[m_count] = b;
      m_count++;
    end else begin
      m_ovf = 1'b1;
    end
    m_crc = crc_step(m_crc, b);
    if (fend) begin
      judge_request();
      m_count = 0;
      m_ovf = 1'b0;
      m_crc = 16'hFFFF;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen <= replies_seen + 1;
      if (reply_q.size() == 0) begin
        $error("tx_byte: unexpected transaction, actual %h", out_tdata);
        errors++;
      end else begin
        if (out_tdata !== reply_q[0].data) begin
          $error("tx_byte: expected %h actual %h", reply_q[0].data, out_tdata);
          errors++;
        end
        if (out_tlast !== reply_q[0].last) begin
          $error("last_of_reply: expected %b actual %b", reply_q[0].last, out_tlast);
          errors++;
        end
        void'(reply_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait <= 0;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      out_draw = $urandom_range(0, 5);
      out_wait <= (out_draw == 0) ? 0 : out_draw - 1;
      out_tready <= (out_draw == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= mbrs_pkg::REG_DEVADDR;
    cfg_pwdata <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    m_addr = value;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fend, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_byte(b, fend);
  endtask

  task automatic send_frame(input bit gaps);
    for (int k = 0; k < flen; k++) send_byte(fbuf[k], k == flen - 1, gaps);
    frames_sent++;
  endtask

  task automatic seal_crc();
    logic [15:0] c;
    c = 16'hFFFF;
    for (int k = 0; k < flen - 2; k++) c = crc_step(c, fbuf[k]);
    fbuf[flen - 2] = c[7:0];
    fbuf[flen - 1] = c[15:8];
  endtask

  task automatic build(input logic [7:0] a, input logic [7:0] fn, input logic [15:0] st,
                       input logic [15:0] qty, input int nwords);
    fbuf[0] = a;
    fbuf[1] = fn;
    fbuf[2] = st[15:8];
    fbuf[3] = st[7:0];
    fbuf[4] = qty[15:8];
    fbuf[5] = qty[7:0];
    if (fn == mbrs_pkg::FN_WRITEN) begin
      fbuf[6] = 8'(2 * nwords);
      for (int k = 0; k < 2 * nwords; k++) fbuf[7 + k] = 8'($urandom);
      flen = 9 + 2 * nwords;
    end else begin
      flen = 8;
    end
    seal_crc();
  endtask

  typedef struct {
    logic [7:0]  a;
    logic [7:0]  fn;
    logic [15:0] st;
    logic [15:0] qty;
    int          nwords;
    int          exp_len;
    logic [7:0]  d3;
    logic [7:0]  d4;
  } req_row_t;

  req_row_t rows[18] = '{
    '{8'h02, mbrs_pkg::FN_READ, 16'd0, 16'd1, 0, 7, 8'h00, 8'h01},
    '{8'h02, mbrs_pkg::FN_READ, 16'd7, 16'd1, 0, 7, 8'h00, 8'h08},
    '{8'h02, mbrs_pkg::FN_READ, 16'd0, 16'd8, 0, 21, 8'h00, 8'h01},
    '{8'h02, mbrs_pkg::FN_READ, 16'd0, 16'd9, 0, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_READ, 16'd0, 16'd0, 0, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_READ, 16'd7, 16'd2, 0, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_READ, 16'hFFFF, 16'hFFFF, 0, 0, 8'h00, 8'h00},
    '{8'h00, mbrs_pkg::FN_READ, 16'd0, 16'd1, 0, 0, 8'h00, 8'h00},
    '{8'h05, mbrs_pkg::FN_READ, 16'd0, 16'd1, 0, 0, 8'h00, 8'h00},
    '{8'h02, 8'h04, 16'd0, 16'd1, 0, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_WRITE1, 16'd3, 16'hFFFF, 0, 8, 8'h03, 8'hFF},
    '{8'h02, mbrs_pkg::FN_WRITE1, 16'd8, 16'h1234, 0, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_WRITE1, 16'd0, 16'h0000, 0, 8, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_WRITEN, 16'd0, 16'd8, 8, 8, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_WRITEN, 16'd7, 16'd1, 1, 8, 8'h00, 8'h07},
    '{8'h02, mbrs_pkg::FN_WRITEN, 16'd7, 16'd2, 2, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_WRITEN, 16'd0, 16'd2, 1, 0, 8'h00, 8'h00},
    '{8'h02, mbrs_pkg::FN_READ, 16'd0, 16'd8, 0, -1, 8'h00, 8'h00}
  };

  task automatic random_frame();
    int kind;
    logic [7:0] a;
    logic [15:0] st, q;
    kind = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : m_addr;
    st = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, NREG - 1));
    if (kind < 30) begin
      q = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, NREG - st[2:0]));
      build(a, mbrs_pkg::FN_READ, st, q, 0);
    end else if (kind < 55) begin
      build(a, mbrs_pkg::FN_WRITE1, st, 16'($urandom), 0);
    end else if (kind < 80) begin
      q = 16'($urandom_range(1, NREG - st[2:0]));
      if ($urandom_range(0, 7) == 0) st = 16'($urandom);
      build(a, mbrs_pkg::FN_WRITEN, st, q, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : q);
    end else if (kind < 88) begin
      build(a, mbrs_pkg::FN_READ, st, 16'd1, 0);
      fbuf[$urandom_range(0, flen - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      flen = $urandom_range(1, MAX_FRAME);
      for (int k = 0; k < flen; k++) fbuf[k] = 8'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        fbuf[0] = m_addr;
        if (flen >= 3) seal_crc();
      end
    end
    send_frame(1);
  endtask

  initial begin
    int rid;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = mbrs_pkg::REG_DEVADDR;
    cfg_pwdata = 32'h0;
    frames_sent = 0;
    m_count = 0;
    m_ovf = 1'b0;
    m_crc = 16'hFFFF;
    m_addr = mbrs_pkg::ADDR_DEF;
    for (int k = 0; k < NREG; k++) m_regs[k] = 16'(k + 1);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      build(rows[i].a, rows[i].fn, rows[i].st, rows[i].qty, rows[i].nwords);
      if (rows[i].exp_len >= 0 && reply_q.size() != 0) begin
        $error("reply queue: expected 0 actual %0d", reply_q.size());
        errors++;
      end
      send_frame(i % 2);
      if (rows[i].exp_len >= 0) begin
        if (reply_q.size() != rows[i].exp_len) begin
          $error("reply length: expected %0d actual %0d", rows[i].exp_len, reply_q.size());
          errors++;
        end
        if (rows[i].exp_len > 0 && rows[i].fn != mbrs_pkg::FN_WRITEN &&
            (reply_q[3].data !== rows[i].d3 || reply_q[4].data !== rows[i].d4)) begin
          $error("tx_byte: expected %h%h actual %h%h", rows[i].d3, rows[i].d4,
                 reply_q[3].data, reply_q[4].data);
          errors++;
        end
      end
      drain();
    end

    flen = 34;
    for (int k = 0; k < flen; k++) fbuf[k] = 8'($urandom);
    fbuf[0] = m_addr;
    send_frame(0);
    flen = 1;
    fbuf[0] = 8'hFF;
    send_frame(0);
    drain();

    cfg_write(8'd247);
    build(8'd247, mbrs_pkg::FN_READ, 16'd0, 16'd8, 0);
    send_frame(0);
    drain();
    cfg_write(8'd1);

    for (int phase = 0; phase < 2; phase++) begin
      for (rid = 0; rid < 2; rid++) random_frame();
      drain();
      cfg_write((phase == 1) ? 8'd0 : 8'($urandom_range(1, 247)));
      for (rid = 0; rid < 2; rid++) random_frame();
      drain();
      cfg_write(mbrs_pkg::ADDR_DEF);
    end

    drain();
    $display("Frames sent: %0d, reply bytes checked: %0d", frames_sent, replies_seen);
    $display("Covered reads, single and block writes, address changes and malformed frames.");
    if (errors == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
